// ===== rtl/cips_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cips_pkg: shared types and constants of the pump sequencer
// Phase codes, register indexes, word layouts and the seven-segment table.
// ----------------------------------------------------------------------------
package cips_pkg;

   // Sequencer phases.
   typedef enum logic [2:0] {
      PH_FILL     = 3'd0,
      PH_BUZZ     = 3'd1,
      PH_IRRIG    = 3'd2,
      PH_MAN_IDLE = 3'd3,
      PH_MAN_RUN  = 3'd4
   } phase_type;

   // Configuration register indexes.
   localparam logic [1:0] CSR_FILL_ITER  = 2'd0;
   localparam logic [1:0] CSR_BUZZ_COUNT = 2'd1;
   localparam logic [1:0] CSR_IRRIG_STEP = 2'd2;

   localparam logic [5:0] FILL_ITER_RESET  = 6'd21;
   localparam logic [2:0] BUZZ_COUNT_RESET = 3'd2;
   localparam logic [3:0] IRRIG_STEP_RESET = 4'd10;

   localparam logic [3:0] MAX_STEPS  = 4'd10;
   localparam logic [6:0] DIGIT_ZERO = 7'h3F;

   // Input word fields, high_float in the lowest bit.
   typedef struct packed {
      logic off_button;
      logic on_button;
      logic mode_switch;
      logic gate_float;
      logic low_float;
      logic high_float;
   } cips_in_type;

   typedef struct packed {
      logic [3:0] irrigation_steps;
      logic [2:0] buzz_count;
      logic [5:0] fill_iterations;
   } cips_cfg_type;

   // Output latches as held by the sequencer core.
   typedef struct packed {
      logic [6:0] digit;
      logic [2:0] float_leds;
      logic       manual;
      logic       idle;
      logic       buzz;
      logic       gate;
      logic       pump;
   } cips_lat_type;

   function automatic logic [6:0] seg_code(input logic [3:0] digit);
      logic [6:0] code;
      case (digit)
         4'd0:    code = 7'h3F;
         4'd1:    code = 7'h06;
         4'd2:    code = 7'h5B;
         4'd3:    code = 7'h4F;
         4'd4:    code = 7'h66;
         4'd5:    code = 7'h6D;
         4'd6:    code = 7'h7D;
         4'd7:    code = 7'h07;
         4'd8:    code = 7'h7F;
         4'd9:    code = 7'h6F;
         default: code = DIGIT_ZERO;
      endcase
      return code;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/cips_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cips_csr: configuration registers
// Three write-only registers; writes to an unused index are dropped.
// ----------------------------------------------------------------------------
module cips_csr (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [1:0]            csr_addr,
   input  wire logic [5:0]            csr_wdata,
   output cips_pkg::cips_cfg_type     cfg
);

   cips_pkg::cips_cfg_type cfg_ff;
   cips_pkg::cips_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            cips_pkg::CSR_FILL_ITER:  cfg_in.fill_iterations  = csr_wdata;
            cips_pkg::CSR_BUZZ_COUNT: cfg_in.buzz_count       = csr_wdata[2:0];
            cips_pkg::CSR_IRRIG_STEP: cfg_in.irrigation_steps = csr_wdata[3:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fill_iterations  <= cips_pkg::FILL_ITER_RESET;
         cfg_ff.buzz_count       <= cips_pkg::BUZZ_COUNT_RESET;
         cfg_ff.irrigation_steps <= cips_pkg::IRRIG_STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== rtl/cips_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cips_core: phase machine, counters and output latches
// One tick is processed in the cycle step_en is high.
// ----------------------------------------------------------------------------
module cips_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step_en,
   input  wire cips_pkg::cips_in_type  tick,
   input  wire cips_pkg::cips_cfg_type cfg,
   output cips_pkg::cips_lat_type     lat
);

   cips_pkg::phase_type phase_ff, phase_in, auto_phase;
   logic [6:0] tick_ff, tick_in;
   logic [3:0] step_ff, step_in;
   cips_pkg::cips_lat_type lat_ff, lat_in;

   logic       man_phase, fill_ok, on_press, off_press, start_ok;
   logic [5:0] fill_eff;
   logic [2:0] buzz_eff;
   logic [6:0] fill_span, buzz_span, auto_tick, fill_base, fill_next, buzz_next;
   logic       fill_done, buzz_done, irrig_end;
   logic [3:0] steps_n, step_base, step_new, digit_idx;

   assign man_phase = (phase_ff == cips_pkg::PH_MAN_IDLE) ||
                      (phase_ff == cips_pkg::PH_MAN_RUN);
   assign fill_ok   = tick.gate_float & tick.high_float;
   assign on_press  = ~tick.on_button;
   assign off_press = ~tick.off_button;
   assign start_ok  = on_press & tick.low_float & ~off_press;

   // Leaving manual mode restarts the fill phase from tick zero.
   assign auto_phase = man_phase ? cips_pkg::PH_FILL : phase_ff;
   assign auto_tick  = man_phase ? 7'd0 : tick_ff;

   assign fill_eff  = (cfg.fill_iterations == 6'd0) ? 6'd1 : cfg.fill_iterations;
   assign buzz_eff  = (cfg.buzz_count == 3'd0) ? 3'd1 : cfg.buzz_count;
   assign fill_span = {fill_eff, 1'b0};
   assign buzz_span = {3'b000, buzz_eff, 1'b0};

   assign fill_base = ((auto_phase != cips_pkg::PH_FILL) || (auto_tick >= fill_span)) ?
                      7'd0 : auto_tick;
   assign fill_next = fill_base + 7'd1;
   assign fill_done = fill_next >= fill_span;
   assign buzz_next = tick_ff + 7'd1;
   assign buzz_done = buzz_next >= buzz_span;

   assign steps_n   = (cfg.irrigation_steps == 4'd0) ? 4'd1 :
                      (cfg.irrigation_steps > cips_pkg::MAX_STEPS) ? cips_pkg::MAX_STEPS :
                      cfg.irrigation_steps;
   assign step_base = (step_ff >= steps_n) ? steps_n - 4'd1 : step_ff;
   assign step_new  = step_base + 4'd1;
   assign digit_idx = steps_n - step_new;
   assign irrig_end = ~tick.low_float || (step_new >= steps_n);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (tick.mode_switch) begin
         if (phase_ff == cips_pkg::PH_MAN_RUN) begin
            phase_in = (~tick.low_float || off_press) ? cips_pkg::PH_MAN_IDLE :
                                                        cips_pkg::PH_MAN_RUN;
         end else begin
            phase_in = start_ok ? cips_pkg::PH_MAN_RUN : cips_pkg::PH_MAN_IDLE;
         end
      end else begin
         unique case (auto_phase)
            cips_pkg::PH_BUZZ:  phase_in = buzz_done ? cips_pkg::PH_IRRIG : cips_pkg::PH_BUZZ;
            cips_pkg::PH_IRRIG: phase_in = irrig_end ? cips_pkg::PH_FILL : cips_pkg::PH_IRRIG;
            default: begin
               phase_in = (fill_done && tick.low_float) ? cips_pkg::PH_BUZZ :
                                                          cips_pkg::PH_FILL;
            end
         endcase
      end
   end

   // Counters and output latches.
   always_comb begin
      tick_in = tick_ff;
      step_in = step_ff;
      lat_in  = lat_ff;
      lat_in.manual     = tick.mode_switch;
      lat_in.float_leds = {~tick.gate_float, ~tick.low_float, ~tick.high_float};
      if (tick.mode_switch) begin
         lat_in.digit = cips_pkg::DIGIT_ZERO;
         if (!man_phase) begin
            tick_in     = 7'd0;
            step_in     = 4'd0;
            lat_in.buzz = 1'b0;
         end
         if (phase_ff == cips_pkg::PH_MAN_RUN) begin
            lat_in.pump = tick.low_float & ~off_press;
            lat_in.gate = 1'b0;
            lat_in.idle = 1'b0;
         end else if (start_ok) begin
            lat_in.pump = 1'b1;
            lat_in.gate = 1'b0;
            lat_in.idle = 1'b0;
         end else begin
            lat_in.pump = 1'b0;
            lat_in.gate = fill_ok;
            lat_in.idle = 1'b1;
         end
      end else begin
         unique case (auto_phase)
            cips_pkg::PH_BUZZ: begin
               lat_in.pump = 1'b0;
               lat_in.gate = 1'b0;
               lat_in.idle = 1'b0;
               lat_in.buzz = ~tick_ff[0];
               tick_in     = buzz_done ? 7'd0 : buzz_next;
               if (buzz_done) begin
                  step_in = 4'd0;
               end
            end
            cips_pkg::PH_IRRIG: begin
               lat_in.pump  = tick.low_float;
               lat_in.gate  = 1'b0;
               lat_in.idle  = 1'b0;
               lat_in.buzz  = 1'b0;
               lat_in.digit = tick.low_float ? cips_pkg::seg_code(digit_idx) :
                                               cips_pkg::DIGIT_ZERO;
               step_in      = irrig_end ? 4'd0 : step_new;
               if (irrig_end) begin
                  tick_in = 7'd0;
               end
            end
            default: begin
               lat_in.pump = 1'b0;
               lat_in.buzz = 1'b0;
               lat_in.gate = fill_ok & ~(fill_done & tick.low_float);
               lat_in.idle = ~fill_base[0];
               tick_in     = fill_done ? 7'd0 : fill_next;
               step_in     = 4'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= cips_pkg::PH_FILL;
         tick_ff  <= 7'd0;
         step_ff  <= 4'd0;
         lat_ff   <= '{digit: cips_pkg::DIGIT_ZERO, float_leds: 3'd0, manual: 1'b0,
                       idle: 1'b0, buzz: 1'b0, gate: 1'b0, pump: 1'b0};
      end else if (step_en) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         step_ff  <= step_in;
         lat_ff   <= lat_in;
      end
   end

   assign lat = lat_ff;

   a_pumps_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(lat_ff.pump && lat_ff.gate))
      else $error("cistern pump and gate pump driven together");

   // A beep that is on at the last beep tick carries into the first
   // countdown tick, which then clears it.
   a_buzz_phase: assert property (@(posedge clock) disable iff (reset)
      lat_ff.buzz |-> ((phase_ff == cips_pkg::PH_BUZZ) ||
                       (phase_ff == cips_pkg::PH_IRRIG)))
      else $error("buzzer on outside the beep and countdown phases");

   a_manual_digit: assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == cips_pkg::PH_MAN_IDLE) || (phase_ff == cips_pkg::PH_MAN_RUN))
      |-> (lat_ff.digit == cips_pkg::DIGIT_ZERO))
      else $error("manual mode shows a nonzero digit");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff < cips_pkg::MAX_STEPS)
      else $error("irrigation step count out of range");

endmodule
`default_nettype wire

// ===== rtl/cistern_irrigation_pump_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cistern_irrigation_pump_sequencer: cistern fill and irrigation sequencer
// Takes one 500 ms tick word with float, switch and button levels and
// returns one word of output latches for it.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Width  Contents
//  req_*     in         8      tick word: float, mode switch and button levels
//  rsp_*     out        16     latch word: pumps, buzzer, LEDs, display digit
//  csr_*     in         2+6    register writes: fill, beep and countdown counts
//
// A tick word accepted at one edge is loaded into the input register; once the
// result register is empty or being drained, the phase logic runs it into the
// result register (the core's latches) and rsp_tvalid goes high with it.
// One word is accepted per clock while the result register can advance; the
// phase logic is a single pass with no iteration, so throughput is limited
// only by the result side.
// Synchronous reset puts the sequencer in automatic fill with all latches off
// and the digit at zero; the registers return to 21, 2 and 10.
// When rsp_tready is low the result holds, the input register still fills,
// and req_tready falls only when both are occupied.
// ----------------------------------------------------------------------------
module cistern_irrigation_pump_sequencer (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: high_float, low_float, gate_float, mode_switch, on_button,
   // off_button, two unused bits
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,
   // rsp_tdata: cistern_pump, gate_pump, buzzer, idle_led, auto_led,
   // manual_led, float_leds[2:0], display_code[6:0]
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [15:0] rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [5:0]  csr_wdata
);

   cips_pkg::cips_cfg_type cfg;
   cips_pkg::cips_lat_type lat;
   cips_pkg::cips_in_type  in_ff, in_in;

   logic in_valid_ff, in_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic advance, req_take, step_en;

   // The result register may be loaded when it is empty or being drained.
   assign advance    = ~rsp_valid_ff | rsp_tready;
   assign req_tready = ~in_valid_ff | advance;
   assign req_take   = req_tvalid & req_tready;
   assign step_en    = in_valid_ff & advance;

   assign in_in        = cips_pkg::cips_in_type'(req_tdata[5:0]);
   assign in_valid_in  = req_take | (in_valid_ff & ~advance);
   assign rsp_valid_in = step_en | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Tick payload register; no reset needed.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff <= in_in;
      end
   end

   cips_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The core's latches are the result register: they change only when a
   // new word is loaded, so they hold steady while the result is stalled.
   cips_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .tick    (in_ff),
      .cfg     (cfg),
      .lat     (lat)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {lat.digit, lat.float_leds, lat.manual, ~lat.manual,
                        lat.idle, lat.buzz, lat.gate, lat.pump};

endmodule
`default_nettype wire
